FILE: sv/sesq_pkg.sv
// shared types and constants of the servo enable sequencer
package sesq_pkg;

  localparam int DRIVES = 8;
  localparam int DELAY_W = 16;
  localparam int TIME_W = 32;
  localparam int WORD_W = 4;
  localparam int CLASS_W = 2;

  typedef enum logic [WORD_W-1:0] {
    WORD_IDLE    = 4'd0,
    WORD_READY   = 4'd6,
    WORD_ON      = 4'd7,
    WORD_OPERATE = 4'd15
  } word_t;

  typedef enum logic [CLASS_W-1:0] {
    CLS_IMMEDIATE    = 2'd0,
    CLS_TWO_STEP     = 2'd1,
    CLS_THREE_STEP   = 2'd2,
    CLS_TWO_STEP_ALT = 2'd3
  } cls_t;

  // register indexes on the configuration port
  localparam logic [1:0] REG_CLASS_MAP    = 2'd0;
  localparam logic [1:0] REG_FIRST_DELAY  = 2'd1;
  localparam logic [1:0] REG_SECOND_DELAY = 2'd2;

  localparam logic [DRIVES*CLASS_W-1:0] CLASS_MAP_RESET = 16'h5555;
  localparam logic [DELAY_W-1:0] FIRST_DELAY_RESET = 16'd1000;
  localparam logic [DELAY_W-1:0] SECOND_DELAY_RESET = 16'd2000;

  typedef struct packed {
    cls_t               cls;
    logic [DELAY_W-1:0] first_delay;
    logic [DELAY_W-1:0] second_delay;
  } lane_cfg_t;

endpackage

FILE: sv/sesq_lane.sv
// one drive lane: control word sequence, enable history and start time
module sesq_lane (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  logic [sesq_pkg::TIME_W-1:0]        now_ms,
  input  logic                               en,
  input  sesq_pkg::lane_cfg_t                cfg,
  output sesq_pkg::word_t                    word_next
);

  sesq_pkg::word_t               word;
  logic                          prev_en;
  logic [sesq_pkg::TIME_W-1:0]   start_time;
  logic [sesq_pkg::TIME_W-1:0]   start_time_next;
  sesq_pkg::word_t               base;
  logic [sesq_pkg::TIME_W-1:0]   elapsed;
  logic                          past_first;
  logic                          past_second;

  assign elapsed     = now_ms - start_time;
  assign past_first  = elapsed > {{(sesq_pkg::TIME_W-sesq_pkg::DELAY_W){1'b0}}, cfg.first_delay};
  assign past_second = elapsed > {{(sesq_pkg::TIME_W-sesq_pkg::DELAY_W){1'b0}}, cfg.second_delay};

  always_comb begin
    // an enable change drops the word back to idle first
    base = (en != prev_en) ? sesq_pkg::WORD_IDLE : word;
    word_next = base;
    start_time_next = start_time;
    if (en && base != sesq_pkg::WORD_OPERATE) begin
      case (cfg.cls) inside
        sesq_pkg::CLS_IMMEDIATE: begin
          if (base == sesq_pkg::WORD_IDLE) word_next = sesq_pkg::WORD_OPERATE;
        end
        sesq_pkg::CLS_THREE_STEP: begin
          if (base == sesq_pkg::WORD_IDLE) begin
            word_next = sesq_pkg::WORD_READY;
            start_time_next = now_ms;
          end else if (base == sesq_pkg::WORD_READY && past_first) begin
            word_next = sesq_pkg::WORD_ON;
          end else if (base == sesq_pkg::WORD_ON && past_second) begin
            word_next = sesq_pkg::WORD_OPERATE;
          end
        end
        sesq_pkg::CLS_TWO_STEP, sesq_pkg::CLS_TWO_STEP_ALT: begin
          if (base == sesq_pkg::WORD_IDLE) begin
            word_next = sesq_pkg::WORD_READY;
            start_time_next = now_ms;
          end else if (base == sesq_pkg::WORD_READY && past_first) begin
            word_next = sesq_pkg::WORD_OPERATE;
          end
        end
        default: word_next = base;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word    <= sesq_pkg::WORD_IDLE;
      prev_en <= 1'b0;
    end else if (step) begin
      word    <= word_next;
      prev_en <= en;
    end
  end

  // start time is only read in ready or on, which always records it first
  always_ff @(posedge clk) begin
    if (step) begin
      start_time <= start_time_next;
    end
  end

endmodule

FILE: sv/sesq_merge.sv
// merge stage: packs the lane words into the registered result item
module sesq_merge (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          load,
  input  sesq_pkg::word_t [sesq_pkg::DRIVES-1:0]        words,
  input  logic                                          out_stall,
  output logic                                          out_valid,
  output logic [sesq_pkg::DRIVES*sesq_pkg::WORD_W-1:0]  control_words,
  output logic [sesq_pkg::DRIVES-1:0]                   operational_mask
);

  logic [sesq_pkg::DRIVES*sesq_pkg::WORD_W-1:0] packed_words;
  logic [sesq_pkg::DRIVES-1:0]                  oper;

  always_comb begin
    for (int i = 0; i < sesq_pkg::DRIVES; i++) begin
      packed_words[i*sesq_pkg::WORD_W +: sesq_pkg::WORD_W] = words[i];
      oper[i] = (words[i] == sesq_pkg::WORD_OPERATE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      control_words    <= packed_words;
      operational_mask <= oper;
    end
  end

endmodule

FILE: sv/servo_enable_sequencer_core.sv
// top level of the servo enable sequencer: config registers, drive lanes, merge
// Takes one item per clock unless stalled: each item (a millisecond timestamp and
// one enable bit per drive) updates all eight drive lanes in the same cycle, one
// lane per drive, and the merged control words enter the output register, where
// they show in the cycle after. Input is stalled only while that register holds
// a result that is itself stalled, so with a free output the block sustains one
// item every cycle. Each lane: one 32-bit elapsed-time subtract and two compares.
// Configuration: class map at 0x0, first delay at 0x4, second delay at 0x8.
module servo_enable_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] now_ms,
  input  logic [7:0]  enable_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] control_words,
  output logic [7:0]  operational_mask,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [sesq_pkg::DRIVES*sesq_pkg::CLASS_W-1:0] class_map;
  logic [sesq_pkg::DELAY_W-1:0]                  first_delay;
  logic [sesq_pkg::DELAY_W-1:0]                  second_delay;
  logic                                          cfg_write;
  logic                                          accept;
  sesq_pkg::word_t [sesq_pkg::DRIVES-1:0]        lane_words;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_map    <= sesq_pkg::CLASS_MAP_RESET;
      first_delay  <= sesq_pkg::FIRST_DELAY_RESET;
      second_delay <= sesq_pkg::SECOND_DELAY_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        sesq_pkg::REG_CLASS_MAP:    class_map    <= pwdata[15:0];
        sesq_pkg::REG_FIRST_DELAY:  first_delay  <= pwdata[15:0];
        sesq_pkg::REG_SECOND_DELAY: second_delay <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      sesq_pkg::REG_CLASS_MAP:    prdata = {16'd0, class_map};
      sesq_pkg::REG_FIRST_DELAY:  prdata = {16'd0, first_delay};
      sesq_pkg::REG_SECOND_DELAY: prdata = {16'd0, second_delay};
      default:                    prdata = 32'd0;
    endcase
  end

  for (genvar g = 0; g < sesq_pkg::DRIVES; g++) begin : g_lane
    sesq_pkg::lane_cfg_t lane_cfg;

    assign lane_cfg.cls = sesq_pkg::cls_t'(class_map[g*sesq_pkg::CLASS_W +: sesq_pkg::CLASS_W]);
    assign lane_cfg.first_delay  = first_delay;
    assign lane_cfg.second_delay = second_delay;

    sesq_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .step      (accept),
      .now_ms    (now_ms),
      .en        (enable_mask[g]),
      .cfg       (lane_cfg),
      .word_next (lane_words[g])
    );
  end

  sesq_merge u_merge (
    .clk              (clk),
    .rst              (rst),
    .load             (accept),
    .words            (lane_words),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .control_words    (control_words),
    .operational_mask (operational_mask)
  );

  // every accepted item leaves a result in the output register
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  // a result only appears after an item was accepted
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(accept))
    else $error("result without an accepted item");

  // operational bit of drive 0 tracks its control word
  a_oper_lane0: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (operational_mask[0] == (control_words[3:0] == 4'hF)))
    else $error("operational mask disagrees with control word");

  // a stalled result is held until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(control_words)))
    else $error("stalled result changed");

endmodule
